// File: rtl/biou_pkg.sv
package biou_pkg;

    // Field sizes.
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 15;

    // Width of a span of inclusive coordinates; it can reach 2**COORD_BITS.
    localparam int CW = COORD_BITS + 1;
    // Full product width of two spans.
    localparam int PW = 2 * CW;
    // Width of an area; it can reach 2**(2*COORD_BITS).
    localparam int AW = 2 * COORD_BITS + 1;
    // Width of the union, which is at most the sum of two areas.
    localparam int UW = AW + 1;
    // Width of the partial remainder, with one spare bit for the shift.
    localparam int RW = UW + 1;
    // Quotient width: one integer bit and FRAC_BITS fraction bits.
    localparam int QW = FRAC_BITS + 1;

    // Pipeline depth: spans, products and union, then one quotient bit per stage.
    localparam int NFRONT = 3;
    localparam int NDIV   = QW;
    localparam int NSTAGE = NFRONT + NDIV;

    // Transactions in flight can fill every stage plus the skid register.
    localparam int CNT_W = $clog2(NSTAGE + 2);

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord a_left;
        t_coord a_top;
        t_coord a_right;
        t_coord a_bottom;
        t_coord b_left;
        t_coord b_top;
        t_coord b_right;
        t_coord b_bottom;
        logic   last_pair;
    } t_pair;

    typedef struct packed {
        logic [QW-1:0] overlap_ratio;
        logic          last_result;
    } t_ratio;

endpackage

// File: rtl/biou_if.sv
interface biou_in_if;
    import biou_pkg::*;

    logic  valid;
    logic  ready;
    t_pair data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface biou_out_if;
    import biou_pkg::*;

    logic   valid;
    logic   ready;
    t_ratio data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/box_intersection_over_union.sv
// An accepted pair passes through the span, area and union stages, then the divider stages, to the output.
// Throughput: one pair per cycle while the output side takes one result per cycle.
// The depth is set by the restoring divider, which resolves one quotient bit per stage.
// Reset (synchronous, active low) clears every stage valid bit and the skid valid flag;
// the block takes pairs in the first cycle after reset is released.
module box_intersection_over_union (
    input logic        i_clk,
    input logic        i_rst_n,
    biou_in_if.sink    i_pair,
    biou_out_if.source o_ratio
);
    import biou_pkg::*;

    // Stage valid bits and the last flag travel alongside the data. Stage 0 holds the
    // spans, stage 1 the areas, stage 2 the union, and stages 3 onward the divider.
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] r_last;

    // The whole pipeline moves together. It stops only when the skid register is
    // occupied, so the stall signal comes straight from a flop.
    logic w_en;
    logic w_accept;

    // Stage 0: spans of the overlap and of each box.
    logic [CW-1:0] r_s1_cw, r_s1_rh, r_s1_wa, r_s1_ha, r_s1_wb, r_s1_hb;
    logic [CW-1:0] n_s1_cw, n_s1_rh, n_s1_wa, n_s1_ha, n_s1_wb, n_s1_hb;

    // Stage 1: the three areas.
    logic [AW-1:0] r_s2_inter, r_s2_area_a, r_s2_area_b;
    logic [PW-1:0] w_prod_i, w_prod_a, w_prod_b;

    // Stage 2: intersection and union, ready for the divider.
    logic [AW-1:0] r_s3_inter;
    logic [UW-1:0] r_s3_uni;
    logic [UW-1:0] n_s3_uni;

    // Divider stages.
    logic [RW-1:0] r_rem [NDIV];
    logic [UW-1:0] r_div [NDIV];
    logic [QW-1:0] r_quo [NDIV];

    // Skid register on the output side.
    logic   r_skid_vld;
    t_ratio r_skid;
    t_ratio w_tail;

    assign w_en         = !r_skid_vld;
    assign i_pair.ready = w_en;
    assign w_accept     = i_pair.valid && w_en;

    // ------------------------------------------------------------------
    // Stage 0. A box with its far edge before its near edge, or a pair that does not
    // overlap at all, gives an empty intersection. The box spans are then forced to one
    // pixel, which keeps the union nonzero and the quotient at zero.
    // ------------------------------------------------------------------
    always_comb begin
        t_pair  p;
        logic   w_bad;
        t_coord w_x0, w_x1, w_y0, w_y1;

        p = i_pair.data;
        w_bad = (p.a_right < p.a_left) || (p.a_bottom < p.a_top) ||
                (p.b_right < p.b_left) || (p.b_bottom < p.b_top) ||
                (p.a_left > p.b_right) || (p.a_top > p.b_bottom) ||
                (p.a_right < p.b_left) || (p.a_bottom < p.b_top);

        w_x0 = (p.a_left > p.b_left) ? p.a_left : p.b_left;
        w_y0 = (p.a_top > p.b_top) ? p.a_top : p.b_top;
        w_x1 = (p.a_right < p.b_right) ? p.a_right : p.b_right;
        w_y1 = (p.a_bottom < p.b_bottom) ? p.a_bottom : p.b_bottom;

        if (w_bad) begin
            n_s1_cw = '0;
            n_s1_rh = '0;
            n_s1_wa = CW'(1);
            n_s1_ha = CW'(1);
            n_s1_wb = CW'(1);
            n_s1_hb = CW'(1);
        end else begin
            n_s1_cw = CW'(w_x1) - CW'(w_x0) + CW'(1);
            n_s1_rh = CW'(w_y1) - CW'(w_y0) + CW'(1);
            n_s1_wa = CW'(p.a_right) - CW'(p.a_left) + CW'(1);
            n_s1_ha = CW'(p.a_bottom) - CW'(p.a_top) + CW'(1);
            n_s1_wb = CW'(p.b_right) - CW'(p.b_left) + CW'(1);
            n_s1_hb = CW'(p.b_bottom) - CW'(p.b_top) + CW'(1);
        end
    end

    // Stage 1 products. Each is at most 2**(2*COORD_BITS), so the top bit is dropped.
    assign w_prod_i = PW'(r_s1_cw) * PW'(r_s1_rh);
    assign w_prod_a = PW'(r_s1_wa) * PW'(r_s1_ha);
    assign w_prod_b = PW'(r_s1_wb) * PW'(r_s1_hb);

    // Stage 2 union. It is never below the larger area, so it never wraps.
    assign n_s3_uni = UW'(r_s2_area_a) + UW'(r_s2_area_b) - UW'(r_s2_inter);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_cw     <= n_s1_cw;
            r_s1_rh     <= n_s1_rh;
            r_s1_wa     <= n_s1_wa;
            r_s1_ha     <= n_s1_ha;
            r_s1_wb     <= n_s1_wb;
            r_s1_hb     <= n_s1_hb;
            r_s2_inter  <= w_prod_i[AW-1:0];
            r_s2_area_a <= w_prod_a[AW-1:0];
            r_s2_area_b <= w_prod_b[AW-1:0];
            r_s3_inter  <= r_s2_inter;
            r_s3_uni    <= n_s3_uni;
            r_last      <= {r_last[NSTAGE-2:0], i_pair.data.last_pair};
        end
    end

    // ------------------------------------------------------------------
    // Restoring division of inter * 2**FRAC_BITS by the union. The intersection never
    // exceeds the union, so the first stage yields the integer bit directly from the
    // intersection, and each later stage doubles the remainder and yields one fraction
    // bit. The last stage holds the finished ratio.
    // ------------------------------------------------------------------
    for (genvar gk = 0; gk < NDIV; gk++) begin : g_div
        logic [RW-1:0] w_trial;
        logic [UW-1:0] w_dsr;
        logic [QW-1:0] w_qin;
        logic          w_ge;

        if (gk == 0) begin : g_first
            assign w_trial = RW'(r_s3_inter);
            assign w_dsr   = r_s3_uni;
            assign w_qin   = '0;
        end else begin : g_next
            assign w_trial = {r_rem[gk-1][RW-2:0], 1'b0};
            assign w_dsr   = r_div[gk-1];
            assign w_qin   = r_quo[gk-1];
        end

        assign w_ge = (w_trial >= RW'(w_dsr));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[gk] <= w_ge ? (w_trial - RW'(w_dsr)) : w_trial;
                r_div[gk] <= w_dsr;
                r_quo[gk] <= {w_qin[QW-2:0], w_ge};
            end
        end
    end

    // Valid bits shift with the data whenever the pipeline moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTAGE-2:0], w_accept};
        end
    end

    // ------------------------------------------------------------------
    // Output side. When the tail of the pipeline holds a result that the sink does not
    // take, that result moves into the skid register as the pipeline advances. The
    // pipeline then holds until the skid register drains, and the skid result always
    // goes out before the one behind it, so order is kept and nothing is repeated.
    // ------------------------------------------------------------------
    assign w_tail = '{overlap_ratio: r_quo[NDIV-1], last_result: r_last[NSTAGE-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_ratio.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[NSTAGE-1] && !o_ratio.ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid <= w_tail;
        end
    end

    assign o_ratio.valid = r_skid_vld || r_vld[NSTAGE-1];
    assign o_ratio.data  = r_skid_vld ? r_skid : w_tail;

endmodule

// File: rtl/biou_checker.sv
module biou_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input biou_pkg::t_ratio  i_out_data
);
    import biou_pkg::*;

    // Transactions accepted at the input and not yet delivered at the output.
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_in_acc;
    logic             w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_in_acc && !w_out_acc) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_out_acc && !w_in_acc) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // A result that is offered stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("stalled result changed");

    // No result appears without a pair having gone in for it.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !i_out_valid)
        else $error("result offered with nothing in flight");

    // With every stage and the skid register full, the input must push back.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CNT_W'(NSTAGE + 1) |-> !i_in_ready)
        else $error("pair accepted with the pipeline full");

    // The ratio never exceeds one.
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.overlap_ratio <= (QW'(1) << FRAC_BITS))
        else $error("ratio above one");

endmodule

bind box_intersection_over_union biou_checker u_biou_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pair.valid),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_ratio.valid),
    .i_out_ready (o_ratio.ready),
    .i_out_data  (o_ratio.data)
);

// File: sim/box_intersection_over_union_tb.sv
`timescale 1ns / 100ps

module box_intersection_over_union_tb;
    import biou_pkg::*;

    // Random pairs that follow the directed opening.
    localparam int RANDOM_PAIRS = 1000;
    // With this few pairs left to send, neither side idles any more.
    localparam int QUIET_TAIL   = 120;
    // The long output hold-off starts once this many pairs have gone in.
    localparam int HOLD_AFTER   = 300;
    // Length of the hold-off; far more than the pipeline and skid can absorb.
    localparam int HOLD_CYCLES  = 80;
    // Cycles to keep watching after the last expected ratio, for stray outputs.
    localparam int DRAIN_CYCLES = 3 * NSTAGE;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    biou_in_if  pair_if ();
    biou_out_if ratio_if ();

    box_intersection_over_union uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_if),
        .o_ratio (ratio_if)
    );

    // Box pairs still to be offered, and ratios that the block still owes us.
    t_pair  pair_q[$];
    t_ratio ratio_due_q[$];

    int     total_pairs   = 0;
    int     pairs_taken   = 0;
    int     mismatches    = 0;
    int     send_gap      = 0;
    int     recv_gap      = 0;
    logic   hold_off      = 1'b0;
    t_ratio ratio_want;
    t_ratio ratio_got;

    // The clock runs with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Computes the expected intersection over union of one accepted pair.
    // Coordinates are inclusive, so a box from l to r covers r - l + 1 columns
    // and two boxes that share an edge overlap by one pixel. An inverted box
    // counts as empty. The quotient is truncated, never rounded.
    function automatic t_ratio predict_iou(t_pair p);
        t_ratio          r;
        t_coord          lo_x;
        t_coord          hi_x;
        t_coord          lo_y;
        t_coord          hi_y;
        longint unsigned inter;
        longint unsigned area_a;
        longint unsigned area_b;
        longint unsigned uni;
        longint unsigned quot;
        r.last_result   = p.last_pair;
        r.overlap_ratio = '0;
        if (p.a_right < p.a_left || p.a_bottom < p.a_top ||
            p.b_right < p.b_left || p.b_bottom < p.b_top)
            return r;
        if (p.a_left > p.b_right || p.a_top > p.b_bottom ||
            p.a_right < p.b_left || p.a_bottom < p.b_top)
            return r;
        lo_x   = (p.a_right < p.b_right) ? p.a_right : p.b_right;
        hi_x   = (p.a_left > p.b_left) ? p.a_left : p.b_left;
        lo_y   = (p.a_bottom < p.b_bottom) ? p.a_bottom : p.b_bottom;
        hi_y   = (p.a_top > p.b_top) ? p.a_top : p.b_top;
        inter  = (64'(lo_x) - 64'(hi_x) + 1) * (64'(lo_y) - 64'(hi_y) + 1);
        area_a = (64'(p.a_right) - 64'(p.a_left) + 1) *
                 (64'(p.a_bottom) - 64'(p.a_top) + 1);
        area_b = (64'(p.b_right) - 64'(p.b_left) + 1) *
                 (64'(p.b_bottom) - 64'(p.b_top) + 1);
        uni    = area_a + area_b - inter;
        quot   = (inter << FRAC_BITS) / uni;
        r.overlap_ratio = quot[QW-1:0];
        return r;
    endfunction

    function automatic t_coord clamp_coord(int v);
        int top_coord;
        top_coord = (1 << COORD_BITS) - 1;
        if (v < 0)
            return '0;
        if (v > top_coord)
            return t_coord'(top_coord);
        return t_coord'(v);
    endfunction

    task automatic add_pair(input int al, input int at, input int ar, input int ab,
                            input int bl, input int bt, input int br, input int bb,
                            input bit last);
        t_pair p;
        p.a_left    = t_coord'(al);
        p.a_top     = t_coord'(at);
        p.a_right   = t_coord'(ar);
        p.a_bottom  = t_coord'(ab);
        p.b_left    = t_coord'(bl);
        p.b_top     = t_coord'(bt);
        p.b_right   = t_coord'(br);
        p.b_bottom  = t_coord'(bb);
        p.last_pair = last;
        pair_q.push_back(p);
    endtask

    // Draws a well-formed box whose corner lies within the spread of (cx, cy)
    // and whose sides are at most the spread long.
    task automatic rand_box(input int cx, input int cy, input int spread,
                            output t_coord l, output t_coord t,
                            output t_coord r, output t_coord b);
        l = clamp_coord(cx + int'($urandom_range(0, 2 * spread)) - spread);
        t = clamp_coord(cy + int'($urandom_range(0, 2 * spread)) - spread);
        r = clamp_coord(int'(l) + int'($urandom_range(0, spread)));
        b = clamp_coord(int'(t) + int'($urandom_range(0, spread)));
    endtask

    // Builds one random pair. Half of the pairs are two well-formed boxes placed near
    // each other, so that overlap, touching edges and containment come up
    // often; the rest are wide boxes, copies, inverted boxes and plain noise.
    task automatic add_random_pair();
        t_pair  p;
        t_coord swap;
        int     cx;
        int     cy;
        int     spread;
        int     pick;
        cx     = $urandom_range(0, (1 << COORD_BITS) - 1);
        cy     = $urandom_range(0, (1 << COORD_BITS) - 1);
        spread = ($urandom_range(0, 3) == 0) ? (1 << COORD_BITS) - 1 :
                 ($urandom_range(0, 1) ? 63 : 7);
        pick   = $urandom_range(0, 19);
        rand_box(cx, cy, spread, p.a_left, p.a_top, p.a_right, p.a_bottom);
        rand_box(cx, cy, spread, p.b_left, p.b_top, p.b_right, p.b_bottom);
        if (pick < 3) begin
            // Raw noise: every coordinate bit toggles, inverted boxes included.
            p.a_left   = t_coord'($urandom);
            p.a_top    = t_coord'($urandom);
            p.a_right  = t_coord'($urandom);
            p.a_bottom = t_coord'($urandom);
            p.b_left   = t_coord'($urandom);
            p.b_top    = t_coord'($urandom);
            p.b_right  = t_coord'($urandom);
            p.b_bottom = t_coord'($urandom);
        end else if (pick < 6) begin
            // Boxes anywhere in the frame, of any size.
            p.a_left   = t_coord'($urandom);
            p.a_top    = t_coord'($urandom);
            p.a_right  = t_coord'($urandom_range(p.a_left, (1 << COORD_BITS) - 1));
            p.a_bottom = t_coord'($urandom_range(p.a_top, (1 << COORD_BITS) - 1));
            p.b_left   = t_coord'($urandom);
            p.b_top    = t_coord'($urandom);
            p.b_right  = t_coord'($urandom_range(p.b_left, (1 << COORD_BITS) - 1));
            p.b_bottom = t_coord'($urandom_range(p.b_top, (1 << COORD_BITS) - 1));
        end else if (pick < 8) begin
            // Identical boxes give exactly one.
            p.b_left   = p.a_left;
            p.b_top    = p.a_top;
            p.b_right  = p.a_right;
            p.b_bottom = p.a_bottom;
        end else if (pick < 10) begin
            // The second box starts on the last column or row of the first.
            if ($urandom_range(0, 1)) begin
                p.b_left  = p.a_right;
                p.b_right = clamp_coord(int'(p.a_right) + int'($urandom_range(0, spread)));
            end else begin
                p.b_top    = p.a_bottom;
                p.b_bottom = clamp_coord(int'(p.a_bottom) + int'($urandom_range(0, spread)));
            end
        end else if (pick < 12) begin
            // One box turned inside out on one axis.
            if ($urandom_range(0, 1)) begin
                swap      = p.a_left;
                p.a_left  = p.a_right;
                p.a_right = swap;
            end else begin
                swap       = p.b_top;
                p.b_top    = p.b_bottom;
                p.b_bottom = swap;
            end
        end
        p.last_pair = ($urandom_range(0, 7) == 0);
        pair_q.push_back(p);
    endtask

    // Sender. A transaction is taken at an edge where valid and ready are both
    // high; its expected ratio is queued at that same edge. The next pair is
    // offered once the current one has gone, unless an idle burst is running.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pair_if.valid <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (pair_if.valid && pair_if.ready) begin
                ratio_due_q.push_back(predict_iou(pair_if.data));
                pairs_taken++;
            end
            if (!pair_if.valid || pair_if.ready) begin
                if (send_gap > 0) begin
                    send_gap      <= send_gap - 1;
                    pair_if.valid <= 1'b0;
                end else if (pair_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                    // The burst starts this cycle and runs on for as long as send_gap says.
                    send_gap      <= $urandom_range(0, 18);
                    pair_if.valid <= 1'b0;
                end else if (pair_q.size() != 0) begin
                    pair_if.data  <= pair_q.pop_front();
                    pair_if.valid <= 1'b1;
                end else begin
                    pair_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every ratio taken is checked field by field against the
    // oldest one still owed. Ready drops in random bursts and for the whole
    // hold-off stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ratio_if.ready <= 1'b0;
            recv_gap       <= 0;
        end else begin
            if (ratio_if.valid && ratio_if.ready) begin
                ratio_got = ratio_if.data;
                if (ratio_due_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected ratio %0d last %0d with nothing owed",
                                 ratio_got.overlap_ratio, ratio_got.last_result);
                end else begin
                    ratio_want = ratio_due_q.pop_front();
                    if (ratio_got.overlap_ratio !== ratio_want.overlap_ratio ||
                        ratio_got.last_result !== ratio_want.last_result) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ratio mismatch: expected %0d last %0d, got %0d last %0d",
                                     ratio_want.overlap_ratio, ratio_want.last_result,
                                     ratio_got.overlap_ratio, ratio_got.last_result);
                    end
                end
            end
            if (hold_off) begin
                ratio_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap       <= recv_gap - 1;
                ratio_if.ready <= 1'b0;
            end else if (pair_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                recv_gap       <= $urandom_range(0, 18);
                ratio_if.ready <= 1'b0;
            end else begin
                ratio_if.ready <= 1'b1;
            end
        end
    end

    // One long stall on the output while the sender keeps offering pairs, so
    // that every stage and the skid register fill and the input backs up.
    initial begin
        wait (pairs_taken >= HOLD_AFTER);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Overall time limit, several times the slowest correct run.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        pair_if.valid  = 1'b0;
        pair_if.data   = '0;
        ratio_if.ready = 1'b0;

        // Identical boxes: the whole frame, the first pixel and the last pixel.
        add_pair(0, 0, 4095, 4095, 0, 0, 4095, 4095, 0);
        add_pair(0, 0, 0, 0, 0, 0, 0, 0, 1);
        add_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 1);
        // Disjoint boxes: second box to the right, left, below and above.
        add_pair(0, 0, 9, 9, 10, 0, 19, 9, 0);
        add_pair(10, 0, 19, 9, 0, 0, 9, 9, 0);
        add_pair(0, 0, 9, 9, 0, 10, 9, 19, 0);
        add_pair(0, 10, 9, 19, 0, 0, 9, 9, 0);
        add_pair(0, 0, 0, 0, 4095, 4095, 4095, 4095, 0);
        // Touching boxes: a shared column, a shared row, a shared corner.
        add_pair(0, 0, 10, 10, 10, 0, 20, 10, 0);
        add_pair(0, 0, 10, 10, 0, 10, 10, 20, 1);
        add_pair(0, 0, 10, 10, 10, 10, 20, 20, 0);
        add_pair(4000, 4000, 4095, 4095, 4095, 4095, 4095, 4095, 0);
        // Inverted boxes on top of a box that would otherwise overlap.
        add_pair(20, 0, 10, 30, 0, 0, 30, 30, 0);
        add_pair(0, 0, 30, 30, 0, 20, 30, 10, 0);
        add_pair(4095, 4095, 0, 0, 0, 0, 4095, 4095, 1);
        // Truncation: one third, a tiny box inside the whole frame, halves.
        add_pair(0, 0, 1, 0, 1, 0, 2, 0, 0);
        add_pair(0, 0, 4095, 4095, 2048, 2048, 2048, 2048, 0);
        add_pair(0, 0, 2, 0, 1, 0, 3, 0, 0);
        add_pair(0, 0, 4095, 4095, 0, 0, 4095, 2047, 0);
        add_pair(0, 0, 4094, 4095, 1, 0, 4095, 4095, 0);
        add_pair(100, 200, 300, 400, 150, 250, 350, 450, 1);
        for (int k = 0; k < RANDOM_PAIRS; k++)
            add_random_pair();
        total_pairs = pair_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Both counters move together in the sender, at the same edge.
        while (pairs_taken < total_pairs || ratio_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/biou_pkg.sv
rtl/biou_if.sv
rtl/box_intersection_over_union.sv
rtl/biou_checker.sv
sim/box_intersection_over_union_tb.sv
